// ----- rtl/core/tpac_pkg.sv -----
// Package for the triac phase angle controller core.
// Holds event codes, register indexes, widths, reset values and the sequencer states.
// No dependencies; every other file of the block refers to it by scoped names.
package tpac_pkg;

    // Event codes carried in the action field of a request.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ZERO  = 2'd1,
        ACT_POWER = 2'd2
    } action_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_DELAY    = 3'd0;
    localparam logic [2:0] REG_POWER_MARGIN = 3'd1;
    localparam logic [2:0] REG_LOAD_STEP    = 3'd2;
    localparam logic [2:0] REG_HALF_PERIOD  = 3'd3;
    localparam logic [2:0] REG_GLITCH_TICKS = 3'd4;
    localparam logic [2:0] REG_SYNC_LOSS    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Field widths.
    localparam int DELAY_W    = 7;
    localparam int POWER_W    = 16;
    localparam int MARGIN_W   = 14;
    localparam int STEP_W     = 10;
    localparam int GLITCH_W   = 10;
    localparam int SINCE_W    = 16;
    localparam int POSITION_W = 8;

    // Firing limits in ticks.
    localparam logic [DELAY_W-1:0] FIRE_LIMIT = 7'd98;
    localparam logic [DELAY_W-1:0] DELAY_OFF  = 7'd100;

    // Register reset values.
    localparam logic [DELAY_W-1:0]  RST_MIN_DELAY    = 7'd10;
    localparam logic [MARGIN_W-1:0] RST_POWER_MARGIN = 14'd0;
    localparam logic [STEP_W-1:0]   RST_LOAD_STEP    = 10'd10;
    localparam logic [GLITCH_W-1:0] RST_GLITCH_TICKS = 10'd80;
    localparam logic [SINCE_W-1:0]  RST_SYNC_LOSS    = 16'd5000;

    // The serial divider produces one quotient bit per cycle over a 16-bit magnitude.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

endpackage

// ----- rtl/core/tpac_if.sv -----
// Valid/ready channel interfaces of the triac phase angle controller core.
// Depends on tpac_pkg for the field widths.
interface tpac_evt_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic signed [tpac_pkg::POWER_W-1:0] power_w;
    logic                                tank_enabled;
    logic                                tank_forced_on;
    logic                                target_reached;
    logic                                mains_present;

    modport source (
        output valid, action, power_w, tank_enabled, tank_forced_on,
               target_reached, mains_present,
        input  ready
    );
    modport sink (
        input  valid, action, power_w, tank_enabled, tank_forced_on,
               target_reached, mains_present,
        output ready
    );
endinterface

interface tpac_res_if;
    logic                         valid;
    logic                         ready;
    logic                         gate;
    logic [tpac_pkg::DELAY_W-1:0] firing_delay;
    logic                         over_production;
    logic                         sync_lost;
    logic                         phase_positive;

    modport source (
        output valid, gate, firing_delay, over_production, sync_lost, phase_positive,
        input  ready
    );
    modport sink (
        input  valid, gate, firing_delay, over_production, sync_lost, phase_positive,
        output ready
    );
endinterface

// ----- rtl/core/triac_phase_angle_controller_core.sv -----
// Triac phase angle controller: zero-cross synchronized firing with a delay regulator.
// Depends on tpac_pkg and on the channel interfaces in tpac_if.sv.
//
// Usage:
// Requests arrive on evt (valid/ready): a timer tick, a zero crossing or a power
// update. Every request gives exactly one result on res (valid/ready), holding the
// gate level, firing delay and status flags after that event.
// Configuration registers are written through cfg_we / cfg_index / cfg_data;
// the user must do so only while no request is in flight, as the block itself
// does not enforce it. Writes to unused indexes are ignored. A tick or zero
// crossing passes from the request capture registers through the apply step
// into the output register. For a power update |power + margin| is formed as
// the request is taken, then the restoring divider runs (one quotient bit per
// cycle), the apply step applies the clamp and the result goes into the output
// register. One request is worked on at a time: a new request is not accepted
// until the last has left the apply step. evt.ready is high only when idle.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next result holds in the apply step until
// the output register frees, and no further request is accepted meanwhile.
// Reset: firing delay 100 (off), gate low, all flags clear, the elapsed count
// saturated, and the configuration registers at their documented defaults.
module triac_phase_angle_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    tpac_evt_if.sink                         evt,
    tpac_res_if.source                       res,
    input  logic                             cfg_we,
    input  logic [tpac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpac_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DW = tpac_pkg::DELAY_W;
    localparam int SW = tpac_pkg::STEP_W;
    localparam int QW = tpac_pkg::DIV_STEPS;
    // Sum of power and margin, and the signed delay arithmetic.
    localparam int SUM_W = tpac_pkg::POWER_W + 1;
    localparam int D_W   = QW + 2;

    // Configuration registers.
    logic [DW-1:0]                        min_delay_reg;
    logic signed [tpac_pkg::MARGIN_W-1:0] power_margin_reg;
    logic [SW-1:0]                        load_step_reg;
    logic                                 half_period_reg;
    logic [tpac_pkg::GLITCH_W-1:0]        glitch_ticks_reg;
    logic [tpac_pkg::SINCE_W-1:0]         sync_loss_reg;

    // Controller state.
    logic [tpac_pkg::POSITION_W-1:0] position_reg, position_next;
    logic [tpac_pkg::SINCE_W-1:0]    since_zero_reg, since_zero_next;
    logic                            phase_reg, phase_next;
    logic                            sync_lost_reg, sync_lost_next;
    logic                            mains_reg, mains_next;
    logic [DW-1:0]                   delay_reg, delay_next;
    logic                            gate_reg, gate_next;
    logic                            overprod_reg, overprod_next;

    // Sequencer and the request being worked on.
    tpac_pkg::state_t          state_reg, state_next;
    tpac_pkg::action_t         act_reg;
    logic                      enabled_reg, forced_reg, reached_reg, mains_in_reg;
    logic                      neg_reg;
    logic [QW-1:0]             quo_reg, quo_next;
    logic [SW:0]               rem_reg, rem_next;
    logic [tpac_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Output register.
    logic          res_valid_reg, res_valid_next;
    logic          res_gate_reg, res_overprod_reg, res_sync_reg, res_phase_reg;
    logic [DW-1:0] res_delay_reg;

    logic evt_fire, slot_free, apply_fire;

    // Combinational helpers.
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        sum_abs;
    logic [SW-1:0]           divisor;
    logic [SW:0]             shifted;
    logic [SW+1:0]           trial;
    logic [QW:0]             quo_adj;
    logic signed [D_W-1:0]   q_signed;
    logic signed [D_W-1:0]   d_sum;
    logic [DW-1:0]           lo;
    logic [DW-1:0]           new_delay;
    logic                    run_regulator;

    assign evt_fire   = evt.valid && evt.ready;
    assign evt.ready  = (state_reg == tpac_pkg::ST_IDLE);
    assign slot_free  = !res_valid_reg || res.ready;
    assign apply_fire = (state_reg == tpac_pkg::ST_APPLY) && slot_free;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg    <= tpac_pkg::RST_MIN_DELAY;
            power_margin_reg <= tpac_pkg::RST_POWER_MARGIN;
            load_step_reg    <= tpac_pkg::RST_LOAD_STEP;
            half_period_reg  <= 1'b0;
            glitch_ticks_reg <= tpac_pkg::RST_GLITCH_TICKS;
            sync_loss_reg    <= tpac_pkg::RST_SYNC_LOSS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpac_pkg::REG_MIN_DELAY:    min_delay_reg    <= cfg_data[DW-1:0];
                tpac_pkg::REG_POWER_MARGIN:
                    power_margin_reg <= cfg_data[tpac_pkg::MARGIN_W-1:0];
                tpac_pkg::REG_LOAD_STEP:    load_step_reg    <= cfg_data[SW-1:0];
                tpac_pkg::REG_HALF_PERIOD:  half_period_reg  <= cfg_data[0];
                tpac_pkg::REG_GLITCH_TICKS:
                    glitch_ticks_reg <= cfg_data[tpac_pkg::GLITCH_W-1:0];
                tpac_pkg::REG_SYNC_LOSS:
                    sync_loss_reg <= cfg_data[tpac_pkg::SINCE_W-1:0];
                default: ;
            endcase
        end
    end

    // Magnitude of power plus margin, formed when a request is accepted.
    always_comb
    begin
        sum = SUM_W'(evt.power_w) + SUM_W'(power_margin_reg);
        sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    // One restoring division step; a zero load step divides by one.
    always_comb
    begin
        divisor = (load_step_reg == '0) ? SW'(1) : load_step_reg;
        shifted = {rem_reg[SW-1:0], quo_reg[QW-1]};
        trial   = {1'b0, shifted} - {2'b00, divisor};
    end

    // Floor quotient, new delay and its clamp.
    always_comb
    begin
        quo_adj  = {1'b0, quo_reg} + (QW+1)'(neg_reg && (rem_reg != '0));
        q_signed = neg_reg ? -$signed({1'b0, quo_adj}) : $signed({1'b0, quo_adj});
        d_sum    = $signed({{(D_W-DW){1'b0}}, delay_reg}) + q_signed;
        lo       = (min_delay_reg > tpac_pkg::DELAY_OFF) ? tpac_pkg::DELAY_OFF
                                                        : min_delay_reg;
        priority if (forced_reg || d_sum < $signed({{(D_W-DW){1'b0}}, lo}))
            new_delay = lo;
        else if (d_sum > $signed({{(D_W-DW){1'b0}}, tpac_pkg::DELAY_OFF}))
            new_delay = tpac_pkg::DELAY_OFF;
        else
            new_delay = d_sum[DW-1:0];
        run_regulator = enabled_reg && !reached_reg && mains_in_reg;
    end

    // Sequencer and divider next state.
    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            tpac_pkg::ST_IDLE:
            begin
                if (evt_fire)
                begin
                    quo_next = sum_abs[QW-1:0];
                    rem_next = '0;
                    cnt_next = tpac_pkg::DIV_CNT_W'(tpac_pkg::DIV_STEPS);
                    if (evt.action == tpac_pkg::ACT_POWER)
                        state_next = tpac_pkg::ST_DIV;
                    else
                        state_next = tpac_pkg::ST_APPLY;
                end
            end
            tpac_pkg::ST_DIV:
            begin
                if (!trial[SW+1])
                begin
                    rem_next = trial[SW:0];
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == tpac_pkg::DIV_CNT_W'(1))
                    state_next = tpac_pkg::ST_APPLY;
            end
            tpac_pkg::ST_APPLY:
            begin
                if (slot_free)
                    state_next = tpac_pkg::ST_IDLE;
            end
            default: state_next = tpac_pkg::ST_IDLE;
        endcase
    end

    // Event update of the controller state.
    always_comb
    begin
        position_next   = position_reg;
        since_zero_next = since_zero_reg;
        phase_next      = phase_reg;
        sync_lost_next  = sync_lost_reg;
        mains_next      = mains_reg;
        delay_next      = delay_reg;
        gate_next       = gate_reg;
        overprod_next   = overprod_reg;
        if (apply_fire)
        begin
            unique case (act_reg)
                tpac_pkg::ACT_TICK:
                begin
                    if (position_reg != '1)
                        position_next = position_reg + 1'b1;
                    if (since_zero_reg != '1)
                        since_zero_next = since_zero_reg + 1'b1;
                    if (position_next > {1'b0, delay_reg}
                        && delay_reg < tpac_pkg::FIRE_LIMIT
                        && mains_reg && !sync_lost_reg
                        && (!half_period_reg || phase_reg))
                        gate_next = 1'b1;
                end
                tpac_pkg::ACT_ZERO:
                begin
                    if (since_zero_reg > {{(tpac_pkg::SINCE_W-tpac_pkg::GLITCH_W){1'b0}},
                                          glitch_ticks_reg})
                    begin
                        position_next   = '0;
                        since_zero_next = '0;
                        gate_next       = 1'b0;
                        phase_next      = !phase_reg;
                    end
                end
                tpac_pkg::ACT_POWER:
                begin
                    mains_next = mains_in_reg;
                    if (run_regulator)
                    begin
                        delay_next    = new_delay;
                        overprod_next = new_delay < tpac_pkg::DELAY_OFF;
                    end
                    else
                    begin
                        delay_next = tpac_pkg::DELAY_OFF;
                        gate_next  = 1'b0;
                    end
                    if (since_zero_reg > sync_loss_reg)
                    begin
                        sync_lost_next = 1'b1;
                        gate_next      = 1'b0;
                    end
                    else
                        sync_lost_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Output register handshake.
    always_comb
    begin
        if (apply_fire)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tpac_pkg::ST_IDLE;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
            position_reg   <= '0;
            since_zero_reg <= '1;
            phase_reg      <= 1'b0;
            sync_lost_reg  <= 1'b0;
            mains_reg      <= 1'b0;
            delay_reg      <= tpac_pkg::DELAY_OFF;
            gate_reg       <= 1'b0;
            overprod_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            res_valid_reg  <= res_valid_next;
            position_reg   <= position_next;
            since_zero_reg <= since_zero_next;
            phase_reg      <= phase_next;
            sync_lost_reg  <= sync_lost_next;
            mains_reg      <= mains_next;
            delay_reg      <= delay_next;
            gate_reg       <= gate_next;
            overprod_reg   <= overprod_next;
        end
    end

    // Request capture, divider datapath and result payload.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (evt_fire)
        begin
            act_reg      <= tpac_pkg::action_t'(evt.action);
            enabled_reg  <= evt.tank_enabled;
            forced_reg   <= evt.tank_forced_on;
            reached_reg  <= evt.target_reached;
            mains_in_reg <= evt.mains_present;
            neg_reg      <= sum[SUM_W-1];
        end
        if (apply_fire)
        begin
            res_gate_reg     <= gate_next;
            res_delay_reg    <= delay_next;
            res_overprod_reg <= overprod_next;
            res_sync_reg     <= sync_lost_next;
            res_phase_reg    <= phase_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.gate            = res_gate_reg;
    assign res.firing_delay    = res_delay_reg;
    assign res.over_production = res_overprod_reg;
    assign res.sync_lost       = res_sync_reg;
    assign res.phase_positive  = res_phase_reg;

    // The reported delay never goes past the off value.
    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.firing_delay <= tpac_pkg::DELAY_OFF)
        else $error("firing delay above off value");

    // A driven gate is never reported together with lost sync.
    a_gate_sync: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.gate |-> !res.sync_lost)
        else $error("gate high while sync is lost");

    // After a request is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.ready |=> !evt.ready)
        else $error("request accepted while busy");

    // The over production flag only rises together with a delay below off.
    a_overprod_delay: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overprod_reg) |-> delay_reg < tpac_pkg::DELAY_OFF)
        else $error("over production flag rose with delay at off");

endmodule
